// File: rtl/core/bst_pkg.sv
// shared types and constants for the bounded set table
`default_nettype none

package bst_pkg;

  // fixed field widths
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned IDX_IN_W     = 10;
  localparam int unsigned POS_OUT_W    = 10;
  localparam int unsigned CNT_OUT_W    = 11;

  // capacity range support: up to 4096 entries, count needs 13 bits
  localparam int unsigned DEF_CAPACITY = 1024;
  localparam int unsigned CNT_MAX_W    = 13;

  // cells per reduction group and the offset width inside a group
  localparam int unsigned GRP_MAX      = 32;
  localparam int unsigned OFF_W        = 5;

  // request operation codes
  typedef enum logic [1:0] {
    FN_ADD    = 2'd0,
    FN_REMOVE = 2'd1,
    FN_FIND   = 2'd2,
    FN_READ   = 2'd3
  } func_e;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SRCH = 2'd1,
    S_FIN  = 2'd2
  } state_e;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic [DATA_W-1:0]    key;
    logic [CNT_MAX_W-1:0] count;
    logic [CNT_MAX_W-1:0] rd_index;
    logic [CNT_MAX_W-1:0] pos;
    logic                 shift_en;
    logic                 load_en;
  } cell_ctrl_t;

  // registered summary of one group of cells
  typedef struct packed {
    logic              hit;
    logic [OFF_W-1:0]  off;
    logic              sel;
    logic [DATA_W-1:0] data;
  } grp_res_t;

endpackage

`default_nettype wire

// File: rtl/core/bst_cell.sv
// one storage cell of the set: holds an entry, compares it and shifts from its neighbor
`default_nettype none

module bst_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire logic                         clk_i,
  input  wire bst_pkg::cell_ctrl_t          ctrl_i,
  input  wire logic [bst_pkg::DATA_W-1:0]   next_i,
  output logic      [bst_pkg::DATA_W-1:0]   data_o,
  output logic                              match_o,
  output logic                              sel_o
);

  localparam logic [bst_pkg::CNT_MAX_W-1:0] MyIdx  = bst_pkg::CNT_MAX_W'(IDX);
  localparam logic [bst_pkg::CNT_MAX_W-1:0] MyNext = bst_pkg::CNT_MAX_W'(IDX + 1);

  logic [bst_pkg::DATA_W-1:0] data_q, data_d;
  logic                       live;

  // entry is part of the set only below the count
  assign live    = (MyIdx < ctrl_i.count);
  assign match_o = live && (data_q == ctrl_i.key);
  assign sel_o   = live && (MyIdx == ctrl_i.rd_index);
  assign data_o  = data_q;

  // compaction shift from the upper neighbor, or append at the count
  always_comb begin
    data_d = data_q;
    if (ctrl_i.shift_en && (MyIdx >= ctrl_i.pos) && (MyNext < ctrl_i.count)) begin
      data_d = next_i;
    end
    if (ctrl_i.load_en && (MyIdx == ctrl_i.count)) begin
      data_d = ctrl_i.key;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

`default_nettype wire

// File: rtl/core/bst_group.sv
// reduces the match and select flags of a group of cells into one registered summary
`default_nettype none

module bst_group #(
  parameter int unsigned GRP_N = 32
) (
  input  wire logic                                   clk_i,
  input  wire logic [GRP_N-1:0]                       match_i,
  input  wire logic [GRP_N-1:0]                       sel_i,
  input  wire logic [GRP_N-1:0][bst_pkg::DATA_W-1:0]  data_i,
  output bst_pkg::grp_res_t                           res_o
);

  bst_pkg::grp_res_t res_q, res_d;

  // at most one live entry matches and at most one is selected, so or-ing is enough
  always_comb begin
    res_d = '0;
    for (int j = 0; j < GRP_N; j++) begin
      if (match_i[j]) begin
        res_d.hit = 1'b1;
        res_d.off = res_d.off | bst_pkg::OFF_W'(j);
      end
      if (sel_i[j]) begin
        res_d.sel  = 1'b1;
        res_d.data = res_d.data | data_i[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

// File: rtl/core/bounded_set_table_unit.sv
// top level of the bounded set table: request sequencer, cell chain and result register
//
// Usage: a request (func_i, value_i, index_i) transfers at a rising edge where start
// is high and busy is low. func_i selects add, remove, find or read by index.
// Exactly one result follows: status_o, found_o, position_o, read_value_o and
// count_o are valid for the single cycle in which done_o is high.
// Sequence: in S_SRCH every cell compares against the key and the flags are
// reduced per group of up to 32 cells into registers; in S_FIN the groups are
// merged and the cells, the count and the result registers are updated; then
// done_o shows the result. busy is low during the done_o cycle, so a new request
// can transfer then, but never while one is in progress. The compare-and-reduce
// pass over the cell row is a two-level tree whose group level is registered.
// Remove shifts all later cells down one place at once through the neighbor links
// of the chain.
// Reset clears the count, done_o and the sequencer; cell contents are left as they are
// and are never observed before being written. done_o cannot be held off: the
// receiver takes each result in the cycle it is shown.
`default_nettype none

module bounded_set_table_unit #(
  parameter int unsigned CAPACITY = bst_pkg::DEF_CAPACITY
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic        [1:0]                   func_i,
  input  wire logic signed [bst_pkg::DATA_W-1:0]   value_i,
  input  wire logic        [bst_pkg::IDX_IN_W-1:0] index_i,
  output logic                                     done_o,
  output logic             [1:0]                   status_o,
  output logic                                     found_o,
  output logic             [bst_pkg::POS_OUT_W-1:0] position_o,
  output logic signed      [bst_pkg::DATA_W-1:0]   read_value_o,
  output logic             [bst_pkg::CNT_OUT_W-1:0] count_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned GRP   = (CAPACITY < bst_pkg::GRP_MAX) ? CAPACITY : bst_pkg::GRP_MAX;
  localparam int unsigned NGRP  = (CAPACITY + GRP - 1) / GRP;

  bst_pkg::state_e state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;

  bst_pkg::func_e                  req_func_q;
  logic [bst_pkg::DATA_W-1:0]      req_value_q;
  logic [bst_pkg::IDX_IN_W-1:0]    req_index_q;

  logic                            done_q, done_d;
  bst_pkg::status_e                status_q, status_d;
  logic                            found_q, found_d;
  logic [bst_pkg::POS_OUT_W-1:0]   position_q, position_d;
  logic [bst_pkg::DATA_W-1:0]      read_value_q, read_value_d;

  bst_pkg::cell_ctrl_t             ctrl;
  logic [CAPACITY-1:0]             match_v;
  logic [CAPACITY-1:0]             sel_v;
  logic [CAPACITY-1:0][bst_pkg::DATA_W-1:0] data_v;
  bst_pkg::grp_res_t               grp_res [NGRP];

  logic                            any_hit;
  logic                            any_sel;
  logic [bst_pkg::CNT_MAX_W-1:0]   hit_pos;
  logic [bst_pkg::DATA_W-1:0]      sel_data;
  logic [bst_pkg::CNT_MAX_W-1:0]   count_ext;

  assign busy      = (state_q != bst_pkg::S_IDLE);
  assign count_ext = bst_pkg::CNT_MAX_W'(count_q);

  // request capture on transfer
  always_ff @(posedge clk_i) begin
    if ((state_q == bst_pkg::S_IDLE) && start) begin
      req_func_q  <= bst_pkg::func_e'(func_i);
      req_value_q <= value_i;
      req_index_q <= index_i;
    end
  end

  // cell chain, each cell takes its upper neighbor on a remove
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [bst_pkg::DATA_W-1:0] nbr;
    if (i + 1 < CAPACITY) begin : g_mid
      assign nbr = data_v[i + 1];
    end else begin : g_last
      assign nbr = data_v[i];
    end
    bst_cell #(
      .IDX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .next_i  (nbr),
      .data_o  (data_v[i]),
      .match_o (match_v[i]),
      .sel_o   (sel_v[i])
    );
  end

  // first reduction level, one registered group per block of cells
  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    localparam int unsigned N = ((CAPACITY - g * GRP) < GRP) ? (CAPACITY - g * GRP) : GRP;
    bst_group #(
      .GRP_N (N)
    ) u_group (
      .clk_i   (clk_i),
      .match_i (match_v[g * GRP +: N]),
      .sel_i   (sel_v[g * GRP +: N]),
      .data_i  (data_v[g * GRP +: N]),
      .res_o   (grp_res[g])
    );
  end

  // second reduction level over the group summaries
  always_comb begin
    any_hit  = 1'b0;
    any_sel  = 1'b0;
    hit_pos  = '0;
    sel_data = '0;
    for (int g = 0; g < NGRP; g++) begin
      if (grp_res[g].hit) begin
        any_hit = 1'b1;
        hit_pos = hit_pos | (bst_pkg::CNT_MAX_W'(g * GRP)
                             + bst_pkg::CNT_MAX_W'(grp_res[g].off));
      end
      if (grp_res[g].sel) begin
        any_sel  = 1'b1;
        sel_data = sel_data | grp_res[g].data;
      end
    end
  end

  // sequencer: next state, cell commands and result
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    done_d       = 1'b0;
    status_d     = bst_pkg::STAT_OK;
    found_d      = 1'b0;
    position_d   = '0;
    read_value_d = '0;

    ctrl          = '0;
    ctrl.key      = req_value_q;
    ctrl.count    = count_ext;
    ctrl.rd_index = bst_pkg::CNT_MAX_W'(req_index_q);
    ctrl.pos      = hit_pos;

    case (state_q)
      bst_pkg::S_IDLE: begin
        if (start) begin
          state_d = bst_pkg::S_SRCH;
        end
      end
      bst_pkg::S_SRCH: begin
        state_d = bst_pkg::S_FIN;
      end
      bst_pkg::S_FIN: begin
        state_d = bst_pkg::S_IDLE;
        done_d  = 1'b1;
        case (req_func_q)
          bst_pkg::FN_ADD: begin
            found_d    = any_hit;
            position_d = any_hit ? bst_pkg::POS_OUT_W'(hit_pos) : '0;
            if (!any_hit) begin
              if (count_ext >= bst_pkg::CNT_MAX_W'(CAPACITY)) begin
                status_d = bst_pkg::STAT_FULL;
              end else begin
                ctrl.load_en = 1'b1;
                count_d      = CNT_W'(count_q + 1'b1);
              end
            end
          end
          bst_pkg::FN_REMOVE: begin
            found_d    = any_hit;
            position_d = any_hit ? bst_pkg::POS_OUT_W'(hit_pos) : '0;
            if (any_hit) begin
              ctrl.shift_en = 1'b1;
              count_d       = CNT_W'(count_q - 1'b1);
            end
          end
          bst_pkg::FN_FIND: begin
            found_d    = any_hit;
            position_d = any_hit ? bst_pkg::POS_OUT_W'(hit_pos) : '0;
          end
          bst_pkg::FN_READ: begin
            if (any_sel) begin
              read_value_d = sel_data;
            end else begin
              status_d = bst_pkg::STAT_RANGE;
            end
          end
          default: begin
            status_d = bst_pkg::STAT_OK;
          end
        endcase
      end
      default: begin
        state_d = bst_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bst_pkg::S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // result payload registers
  always_ff @(posedge clk_i) begin
    status_q     <= status_d;
    found_q      <= found_d;
    position_q   <= position_d;
    read_value_q <= read_value_d;
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign found_o      = found_q;
  assign position_o   = position_q;
  assign read_value_o = read_value_q;
  assign count_o      = bst_pkg::CNT_OUT_W'(count_q);

  // count never passes the capacity
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // a result only follows the finishing step
  a_done_after_fin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == bst_pkg::S_FIN))
    else $error("result strobe without finishing step");

  // a refused add only happens with a full table
  a_full_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == bst_pkg::STAT_FULL)) |-> (count_q == CNT_W'(CAPACITY)))
    else $error("full status with room left");

  // a read never reports a match
  a_read_no_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (req_func_q == bst_pkg::FN_READ)) |-> (!found_o && (position_o == '0)))
    else $error("read result carries a match");

  // a transfer makes the block busy in the next cycle
  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request transfer did not start the sequencer");

endmodule

`default_nettype wire
